// File: rtl/core/bcsc_pkg.sv
// ============================================================================
// bcsc_pkg: shared definitions for the byte-code shader core
// Sizes, instruction codes, controller states and the command and status
// structures that join the controller to the datapath.
// ============================================================================
package bcsc_pkg;

  localparam int MEM_BYTES     = 65536;
  localparam int MEM_AW        = $clog2(MEM_BYTES);
  localparam int REG_COUNT     = 12;
  localparam int REG_IDX_W     = $clog2(REG_COUNT);
  localparam int REG_W         = 32;
  localparam int SCREEN_WIDTH  = 640;
  localparam int SCREEN_HEIGHT = 480;
  localparam int IBUF_BYTES    = 6;
  localparam int DIV_STEPS     = 32;

  // Step counter limits of the sequencer.
  localparam logic [2:0] FETCH_LAST = 3'd6;
  localparam logic [2:0] OPRD_LAST  = 3'd2;
  localparam logic [2:0] LOAD_LAST  = 3'd4;

  // Configuration register indexes.
  localparam logic [1:0] CFG_COLUMN = 2'd0;
  localparam logic [1:0] CFG_ROW    = 2'd1;
  localparam logic [1:0] CFG_STRIDE = 2'd2;

  // Fault codes.
  localparam logic [1:0] FLT_NONE  = 2'd0;
  localparam logic [1:0] FLT_STORE = 2'd1;
  localparam logic [1:0] FLT_OP    = 2'd2;

  // Load and store size codes.
  localparam logic [3:0] SZ_BYTE = 4'd1;
  localparam logic [3:0] SZ_HALF = 4'd2;
  localparam logic [3:0] SZ_WORD = 4'd3;

  // Instruction opcodes.
  localparam logic [7:0] OP_HALT   = 8'h00;
  localparam logic [7:0] OP_LOAD   = 8'h01;
  localparam logic [7:0] OP_ADD    = 8'h06;
  localparam logic [7:0] OP_SUB    = 8'h07;
  localparam logic [7:0] OP_MULS   = 8'h08;
  localparam logic [7:0] OP_MULU   = 8'h09;
  localparam logic [7:0] OP_DIVS   = 8'h0A;
  localparam logic [7:0] OP_DIVU   = 8'h0B;
  localparam logic [7:0] OP_GTS    = 8'h0C;
  localparam logic [7:0] OP_GTU    = 8'h0D;
  localparam logic [7:0] OP_GES    = 8'h0E;
  localparam logic [7:0] OP_GEU    = 8'h0F;
  localparam logic [7:0] OP_EQ     = 8'h10;
  localparam logic [7:0] OP_JUMP   = 8'h11;
  localparam logic [7:0] OP_INC    = 8'h12;
  localparam logic [7:0] OP_DEC    = 8'h13;
  localparam logic [7:0] OP_CLR    = 8'h14;
  localparam logic [7:0] OP_PIXEL  = 8'h15;
  localparam logic [7:0] OP_COLUMN = 8'h16;
  localparam logic [7:0] OP_ROW    = 8'h17;
  localparam logic [7:0] OP_COREID = 8'h18;
  localparam logic [7:0] OP_MODU   = 8'h19;
  localparam logic [7:0] OP_LOADPP = 8'h1A;
  localparam logic [7:0] OP_STORE  = 8'h1B;
  localparam logic [7:0] OP_IMM    = 8'h1C;

  // Jump types.
  localparam logic [3:0] JT_ZERO   = 4'd0;
  localparam logic [3:0] JT_ONE    = 4'd1;
  localparam logic [3:0] JT_ALWAYS = 4'd2;

  typedef enum logic [1:0] {
    HOP_WRITE = 2'd0,
    HOP_READ  = 2'd1,
    HOP_START = 2'd2,
    HOP_TICK  = 2'd3
  } host_op_t;

  typedef enum logic [2:0] {
    CLS_EXEC,
    CLS_MUL,
    CLS_DIV,
    CLS_LDI,
    CLS_LDP,
    CLS_ST
  } cls_t;

  typedef enum logic [4:0] {
    U_NOP,
    U_LATCH,
    U_HOST_WR,
    U_HOST_RD,
    U_HOST_CAP,
    U_START,
    U_FETCH,
    U_OPRD,
    U_MUL,
    U_DIV_START,
    U_LA_SETUP,
    U_CHAIN,
    U_LOAD,
    U_LDWIN,
    U_LDSEL,
    U_STORE,
    U_EXEC,
    U_FINISH
  } uop_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISP,
    S_HWR,
    S_HRD,
    S_HCAP,
    S_START,
    S_FETCH,
    S_OPRD,
    S_DECODE,
    S_MUL,
    S_DIVS,
    S_DIVW,
    S_SETUP,
    S_CHAIN,
    S_LOAD,
    S_LDWIN,
    S_LDSEL,
    S_STORE,
    S_EXEC,
    S_FINISH
  } state_t;

  typedef struct packed {
    uop_t       uop;
    logic [2:0] cnt;
  } cmd_t;

  typedef struct packed {
    host_op_t host_op;
    logic     stopped;
    cls_t     cls;
    logic     store_last;
    logic     div_busy;
    logic     out_free;
  } status_t;

endpackage

// File: rtl/core/bcsc_div.sv
// ============================================================================
// bcsc_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle.
// ============================================================================
module bcsc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [31:0] quotient,
  output logic [31:0] remainder
);
  import bcsc_pkg::*;

  logic [5:0]  count;
  logic [31:0] dsr;
  logic [32:0] shifted;
  logic [32:0] diff;
  logic        ge;

  assign shifted = {remainder, quotient[31]};
  assign diff    = shifted - {1'b0, dsr};
  assign ge      = !diff[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 6'(DIV_STEPS);
    end else if (busy) begin
      count <= count - 6'd1;
      if (count == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      quotient  <= dividend;
      dsr       <= divisor;
    end else if (busy) begin
      remainder <= ge ? diff[31:0] : shifted[31:0];
      quotient  <= {quotient[30:0], ge};
    end
  end

endmodule

// File: rtl/core/bcsc_datapath.sv
// ============================================================================
// bcsc_datapath: memory, register file and execute logic
// Holds the byte memory, registers, program counter, instruction buffer,
// load and store address logic, the divider and the result register.
// ============================================================================
module bcsc_datapath (
  input  logic              clk,
  input  logic              rst,
  input  bcsc_pkg::cmd_t    cmd,
  output bcsc_pkg::status_t status,
  input  logic              cfg_wr_en,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  input  logic [1:0]        opcode,
  input  logic [15:0]       host_address,
  input  logic [7:0]        host_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [7:0]        read_byte,
  output logic              pixel_valid,
  output logic [9:0]        pixel_x,
  output logic [8:0]        pixel_y,
  output logic [23:0]       pixel_color,
  output logic              halted,
  output logic [1:0]        fault,
  output logic [15:0]       program_counter
);
  import bcsc_pkg::*;

  logic [7:0]       mem [MEM_BYTES];
  logic [7:0]       mem_q;
  logic [MEM_AW-1:0] rd_addr;
  logic [MEM_AW-1:0] wr_addr;
  logic [31:0]      rd_sum;
  logic [31:0]      wr_sum;
  logic [7:0]       wr_data;
  logic             wr_en;

  logic [REG_W-1:0] rf [REG_COUNT];

  logic [7:0]  core_column;
  logic [7:0]  core_row;
  logic [8:0]  grid_stride;
  logic [15:0] pc;
  logic        stopped;

  host_op_t    host_op;
  logic [15:0] host_addr;
  logic [7:0]  host_byte;
  logic [7:0]  ibuf [IBUF_BYTES];

  logic [31:0] opa, opb, opc, opd, opx, opy;
  logic [31:0] ladr, acc, lval, lwin, prod;
  logic [3:0]  lsz;
  logic        lmem;

  logic [7:0]  res_read;
  logic        res_pv;
  logic [9:0]  res_px;
  logic [8:0]  res_py;
  logic [23:0] res_col;
  logic [1:0]  res_flt;

  logic [7:0]  op, b1, b2;
  logic [3:0]  lo, hi, b2lo, b2hi;
  logic [31:0] imm;
  logic [2:0]  cnt;
  logic [2:0]  ib_idx;
  logic [1:0]  acc_idx;
  logic        st_size_ok;
  logic [2:0]  store_n;
  cls_t        cls;

  logic [7:0]  rpa_byte, rpb_byte;
  logic [31:0] rpa_val, rpb_val;
  logic [31:0] wofs;
  logic        win_ok;
  logic [31:0] memval;

  logic        div_start;
  logic        div_busy;
  logic [31:0] div_dividend, div_divisor, quo, rem;
  logic [31:0] div_res;

  logic [16:0] cid_prod;
  logic [31:0] core_id;
  logic        ex_wen;
  logic [7:0]  ex_dest;
  logic [31:0] ex_val;
  logic [15:0] ex_pc;
  logic        ex_halt;
  logic [1:0]  ex_flt;
  logic        ex_pix;
  logic        ex_take;
  logic        rf_we;

  assign op      = ibuf[0];
  assign b1      = ibuf[1];
  assign b2      = ibuf[2];
  assign lo      = b1[3:0];
  assign hi      = b1[7:4];
  assign b2lo    = b2[3:0];
  assign b2hi    = b2[7:4];
  assign imm     = {ibuf[5], ibuf[4], ibuf[3], ibuf[2]};
  assign cnt     = cmd.cnt;
  assign ib_idx  = cnt - 3'd1;
  assign acc_idx = 2'(cnt - 3'd1);

  assign st_size_ok = (b2hi == SZ_BYTE) || (b2hi == SZ_HALF) || (b2hi == SZ_WORD);
  assign store_n    = (b2hi == SZ_WORD) ? 3'd4 : b2hi[2:0];

  always_comb begin
    case (op) inside
      OP_MULS, OP_MULU:          cls = CLS_MUL;
      OP_DIVS, OP_DIVU, OP_MODU: cls = CLS_DIV;
      OP_LOAD:                   cls = CLS_LDI;
      OP_LOADPP:                 cls = CLS_LDP;
      OP_STORE:                  cls = st_size_ok ? CLS_ST : CLS_EXEC;
      default:                   cls = CLS_EXEC;
    endcase
  end

  assign status.host_op    = host_op;
  assign status.stopped    = stopped;
  assign status.cls        = cls;
  assign status.store_last = (cnt == store_n - 3'd1);
  assign status.div_busy   = div_busy;
  assign status.out_free   = !out_valid || out_ready;

  // Memory address selection: one read port and one write port.
  always_comb begin
    case (cmd.uop)
      U_FETCH: rd_sum = {16'b0, pc} + 32'(cnt);
      U_LOAD:  rd_sum = ladr + 32'(cnt);
      default: rd_sum = {16'b0, host_addr};
    endcase
  end
  assign rd_addr = rd_sum[MEM_AW-1:0];

  assign wr_en   = (cmd.uop == U_HOST_WR) || (cmd.uop == U_STORE);
  assign wr_sum  = (cmd.uop == U_STORE) ? lval + 32'(cnt) : {16'b0, host_addr};
  assign wr_addr = wr_sum[MEM_AW-1:0];
  assign wr_data = (cmd.uop == U_STORE) ? opd[8*cnt[1:0] +: 8] : host_byte;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    mem_q <= mem[rd_addr];
  end

  // Register window of the load address space.
  assign wofs   = ladr - 32'(MEM_BYTES + 1);
  assign win_ok = (ladr > 32'(MEM_BYTES)) && (wofs < 32'(REG_COUNT));

  // Two register file read ports; an index past the file reads as zero.
  always_comb begin
    rpa_byte = 8'hFF;
    rpb_byte = 8'hFF;
    case (cmd.uop)
      U_OPRD: begin
        case (cnt)
          3'd0: begin
            rpa_byte = {4'b0, lo};
            rpb_byte = {4'b0, hi};
          end
          3'd1: begin
            rpa_byte = b1;
            rpb_byte = {4'b0, b2lo};
          end
          default: begin
            rpa_byte = 8'd0;
            rpb_byte = 8'd1;
          end
        endcase
      end
      U_LDWIN: rpa_byte = win_ok ? wofs[7:0] : 8'hFF;
      default: ;
    endcase
  end
  assign rpa_val = (rpa_byte < 8'(REG_COUNT)) ? rf[rpa_byte[REG_IDX_W-1:0]] : '0;
  assign rpb_val = (rpb_byte < 8'(REG_COUNT)) ? rf[rpb_byte[REG_IDX_W-1:0]] : '0;

  always_comb begin
    case (lsz)
      SZ_BYTE: memval = {24'b0, acc[7:0]};
      SZ_HALF: memval = {16'b0, acc[15:0]};
      SZ_WORD: memval = acc;
      default: memval = '0;
    endcase
  end

  // The divider works on magnitudes; the sign is put back at execute.
  assign div_start    = (cmd.uop == U_DIV_START);
  assign div_dividend = (op == OP_DIVS && opa[31]) ? (32'd0 - opa) : opa;
  assign div_divisor  = (op == OP_DIVS && opb[31]) ? (32'd0 - opb) : opb;

  bcsc_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .busy      (div_busy),
    .quotient  (quo),
    .remainder (rem)
  );

  assign div_res  = (op == OP_DIVS && (opa[31] ^ opb[31])) ? (32'd0 - quo) : quo;
  assign cid_prod = 17'(grid_stride) * 17'(core_row);
  assign core_id  = 32'(cid_prod) + 32'(core_column);

  always_comb begin
    ex_wen  = 1'b1;
    ex_dest = {4'b0, lo};
    ex_val  = '0;
    ex_pc   = pc + 16'd2;
    ex_halt = 1'b0;
    ex_flt  = FLT_NONE;
    ex_pix  = 1'b0;
    ex_take = 1'b0;
    case (op) inside
      OP_HALT: begin
        ex_wen  = 1'b0;
        ex_halt = 1'b1;
        ex_pc   = pc;
      end
      OP_LOAD: begin
        ex_val = lval;
        ex_pc  = pc + 16'd6;
      end
      OP_ADD:           ex_val = opa + opb;
      OP_SUB:           ex_val = opa - opb;
      OP_MULS, OP_MULU: ex_val = prod;
      OP_DIVS, OP_DIVU: ex_val = (opb == '0) ? '0 : div_res;
      OP_MODU:          ex_val = (opb == '0) ? '0 : rem;
      OP_GTS:           ex_val = {31'b0, $signed(opa) > $signed(opb)};
      OP_GTU:           ex_val = {31'b0, opa > opb};
      OP_GES:           ex_val = {31'b0, $signed(opa) >= $signed(opb)};
      OP_GEU:           ex_val = {31'b0, opa >= opb};
      OP_EQ:            ex_val = {31'b0, opa == opb};
      OP_JUMP: begin
        ex_wen  = 1'b0;
        ex_take = ((hi == JT_ZERO) && (opa == 32'd0)) ||
                  ((hi == JT_ONE) && (opa == 32'd1)) || (hi == JT_ALWAYS);
        ex_pc   = ex_take ? imm[15:0] : pc + 16'd6;
      end
      OP_INC:    ex_val = opa + 32'd1;
      OP_DEC:    ex_val = opa - 32'd1;
      OP_CLR:    ex_val = '0;
      OP_PIXEL: begin
        ex_wen = 1'b0;
        ex_pc  = pc + 16'd3;
        ex_pix = (opx < 32'(SCREEN_WIDTH)) && (opy < 32'(SCREEN_HEIGHT));
      end
      OP_COLUMN: ex_val = {24'b0, core_column};
      OP_ROW:    ex_val = {24'b0, core_row};
      OP_COREID: ex_val = core_id;
      OP_LOADPP: begin
        ex_dest = {4'b0, b2lo};
        ex_val  = lval;
        ex_pc   = pc + 16'd3;
      end
      OP_STORE: begin
        ex_wen = 1'b0;
        ex_pc  = pc + 16'd3;
        if (!st_size_ok) begin
          ex_flt = FLT_STORE;
        end
      end
      OP_IMM: begin
        ex_dest = b1;
        ex_val  = imm;
        ex_pc   = pc + 16'd6;
      end
      default: begin
        ex_wen  = 1'b0;
        ex_halt = 1'b1;
        ex_pc   = pc;
        ex_flt  = FLT_OP;
      end
    endcase
  end

  assign rf_we = (cmd.uop == U_EXEC) && ex_wen && (ex_dest < 8'(REG_COUNT));

  // Architectural and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= '0;
      stopped     <= 1'b1;
      core_column <= '0;
      core_row    <= '0;
      grid_stride <= 9'd1;
      out_valid   <= 1'b0;
      for (int i = 0; i < REG_COUNT; i++) begin
        rf[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_COLUMN: core_column <= cfg_data[7:0];
          CFG_ROW:    core_row    <= cfg_data[7:0];
          CFG_STRIDE: grid_stride <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.uop == U_FINISH) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.uop)
        U_START: begin
          pc      <= host_addr;
          stopped <= 1'b0;
        end
        U_EXEC: begin
          pc <= ex_pc;
          if (ex_halt) begin
            stopped <= 1'b1;
          end
        end
        default: ;
      endcase
      if (rf_we) begin
        rf[ex_dest[REG_IDX_W-1:0]] <= ex_val;
      end
    end
  end

  // Working registers and the result register.
  always_ff @(posedge clk) begin
    case (cmd.uop)
      U_LATCH: begin
        host_op   <= host_op_t'(opcode);
        host_addr <= host_address;
        host_byte <= host_data;
        res_read  <= '0;
        res_pv    <= 1'b0;
        res_px    <= '0;
        res_py    <= '0;
        res_col   <= '0;
        res_flt   <= FLT_NONE;
      end
      U_HOST_CAP: res_read <= mem_q;
      U_FETCH: begin
        if (cnt != 3'd0) begin
          ibuf[ib_idx] <= mem_q;
        end
      end
      U_OPRD: begin
        case (cnt)
          3'd0: begin
            opa <= rpa_val;
            opb <= rpb_val;
          end
          3'd1: begin
            opc <= rpa_val;
            opd <= rpb_val;
          end
          default: begin
            opx <= rpa_val;
            opy <= rpb_val;
          end
        endcase
      end
      U_MUL: prod <= opa * opb;
      U_LA_SETUP: begin
        if (op == OP_LOAD) begin
          ladr <= imm;
          lsz  <= hi;
          lmem <= 1'b0;
        end else begin
          // Pointer load; a store takes its destination from memory alone.
          ladr <= opc;
          lsz  <= SZ_WORD;
          lmem <= (op == OP_STORE);
        end
      end
      U_CHAIN: begin
        ladr <= lval;
        lsz  <= b2hi;
        lmem <= 1'b0;
      end
      U_LOAD: begin
        if (cnt != 3'd0) begin
          acc[8*acc_idx +: 8] <= mem_q;
        end
      end
      U_LDWIN: lwin <= rpa_val;
      U_LDSEL: lval <= (lmem || (ladr < 32'(MEM_BYTES))) ? memval : lwin;
      U_EXEC: begin
        res_pv  <= ex_pix;
        res_px  <= ex_pix ? opx[9:0] : '0;
        res_py  <= ex_pix ? opy[8:0] : '0;
        res_col <= ex_pix ? {opa[7:0], opb[7:0], opd[7:0]} : '0;
        res_flt <= ex_flt;
      end
      U_FINISH: begin
        read_byte       <= res_read;
        pixel_valid     <= res_pv;
        pixel_x         <= res_px;
        pixel_y         <= res_py;
        pixel_color     <= res_col;
        fault           <= res_flt;
        halted          <= stopped;
        program_counter <= pc;
      end
      default: ;
    endcase
  end

endmodule

// File: rtl/core/bcsc_ctrl.sv
// ============================================================================
// bcsc_ctrl: sequencer for the byte-code shader core
// Steps each input beat through fetch, operand read, load, store, divide and
// execute phases, issuing one micro-command per cycle to the datapath.
// ============================================================================
module bcsc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bcsc_pkg::status_t status,
  output bcsc_pkg::cmd_t    cmd
);
  import bcsc_pkg::*;

  state_t     state, state_next;
  logic [2:0] cnt, cnt_next;
  logic       second, second_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      cnt    <= '0;
      second <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      second <= second_next;
    end
  end

  always_comb begin
    state_next  = state;
    cnt_next    = '0;
    second_next = second;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_DISP;
      S_DISP: begin
        unique case (status.host_op)
          HOP_WRITE: state_next = S_HWR;
          HOP_READ:  state_next = S_HRD;
          HOP_START: state_next = S_START;
          HOP_TICK:  state_next = status.stopped ? S_FINISH : S_FETCH;
        endcase
      end
      S_HWR, S_START, S_HCAP: state_next = S_FINISH;
      S_HRD: state_next = S_HCAP;
      S_FETCH: begin
        if (cnt == FETCH_LAST) state_next = S_OPRD;
        else cnt_next = cnt + 3'd1;
      end
      S_OPRD: begin
        if (cnt == OPRD_LAST) state_next = S_DECODE;
        else cnt_next = cnt + 3'd1;
      end
      S_DECODE: begin
        second_next = 1'b0;
        case (status.cls)
          CLS_MUL:                 state_next = S_MUL;
          CLS_DIV:                 state_next = S_DIVS;
          CLS_LDI, CLS_LDP, CLS_ST: state_next = S_SETUP;
          default:                 state_next = S_EXEC;
        endcase
      end
      S_MUL:  state_next = S_EXEC;
      S_DIVS: state_next = S_DIVW;
      S_DIVW: if (!status.div_busy) state_next = S_EXEC;
      S_SETUP, S_CHAIN: state_next = S_LOAD;
      S_LOAD: begin
        if (cnt == LOAD_LAST) state_next = S_LDWIN;
        else cnt_next = cnt + 3'd1;
      end
      S_LDWIN: state_next = S_LDSEL;
      S_LDSEL: begin
        // The double-indirect load runs the load sequence a second time.
        if (status.cls == CLS_LDP && !second) begin
          state_next  = S_CHAIN;
          second_next = 1'b1;
        end else if (status.cls == CLS_ST) begin
          state_next = S_STORE;
        end else begin
          state_next = S_EXEC;
        end
      end
      S_STORE: begin
        if (status.store_last) state_next = S_EXEC;
        else cnt_next = cnt + 3'd1;
      end
      S_EXEC:   state_next = S_FINISH;
      S_FINISH: if (status.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == S_IDLE);
    cmd.cnt  = cnt;
    unique case (state)
      S_IDLE:   cmd.uop = in_valid ? U_LATCH : U_NOP;
      S_HWR:    cmd.uop = U_HOST_WR;
      S_HRD:    cmd.uop = U_HOST_RD;
      S_HCAP:   cmd.uop = U_HOST_CAP;
      S_START:  cmd.uop = U_START;
      S_FETCH:  cmd.uop = U_FETCH;
      S_OPRD:   cmd.uop = U_OPRD;
      S_MUL:    cmd.uop = U_MUL;
      S_DIVS:   cmd.uop = U_DIV_START;
      S_SETUP:  cmd.uop = U_LA_SETUP;
      S_CHAIN:  cmd.uop = U_CHAIN;
      S_LOAD:   cmd.uop = U_LOAD;
      S_LDWIN:  cmd.uop = U_LDWIN;
      S_LDSEL:  cmd.uop = U_LDSEL;
      S_STORE:  cmd.uop = U_STORE;
      S_EXEC:   cmd.uop = U_EXEC;
      S_FINISH: cmd.uop = status.out_free ? U_FINISH : U_NOP;
      default:  cmd.uop = U_NOP;
    endcase
  end

endmodule

// File: rtl/core/byte_code_shader_core_execute.sv
// ============================================================================
// byte_code_shader_core_execute: byte-code shader core, top level
// Channel  | signals                                   | beat taken when
// in       | opcode, host_address, host_data           | in_valid & in_ready
// out      | read_byte, pixel_*, halted, fault, pc     | out_valid & out_ready
// cfg      | cfg_wr_en, cfg_index, cfg_data            | cfg_wr_en
// Fetch and loads read the single memory read port one byte per cycle;
// divide and modulo use the 32-step divider. Reset is synchronous; the
// core starts halted. One beat is in flight at a time; a result waiting in
// the output register holds only the final step of the next beat.
// ============================================================================
module byte_code_shader_core_execute (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [15:0] host_address,
  input  logic [7:0]  host_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  read_byte,
  output logic        pixel_valid,
  output logic [9:0]  pixel_x,
  output logic [8:0]  pixel_y,
  output logic [23:0] pixel_color,
  output logic        halted,
  output logic [1:0]  fault,
  output logic [15:0] program_counter,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  import bcsc_pkg::*;

  cmd_t    cmd;
  status_t status;

  bcsc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  bcsc_datapath u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .opcode          (opcode),
    .host_address    (host_address),
    .host_data       (host_data),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .read_byte       (read_byte),
    .pixel_valid     (pixel_valid),
    .pixel_x         (pixel_x),
    .pixel_y         (pixel_y),
    .pixel_color     (pixel_color),
    .halted          (halted),
    .fault           (fault),
    .program_counter (program_counter)
  );

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second beat taken while one is in flight");

  a_finish_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.uop == U_FINISH) |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  a_fault_halts: assert property (@(posedge clk) disable iff (rst)
    (out_valid && fault == FLT_OP) |-> halted)
    else $error("unknown opcode without halt");

  a_pixel_bounds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && pixel_valid) |->
      ((32'(pixel_x) < 32'(SCREEN_WIDTH)) && (32'(pixel_y) < 32'(SCREEN_HEIGHT))))
    else $error("pixel reported out of bounds");

endmodule
